// ===== rtl/tpf_pkg.sv =====
`default_nettype none
package tpf_pkg;

    localparam int NumPorts = 4;
    localparam int ListLen = 4;
    localparam int PortW = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;
    localparam logic [3:0] MinHeaderWords = 4'd4;

    localparam logic [CfgIdxW-1:0] CfgPortCount = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgPortA = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgPortB = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgPortC = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgPortD = 3'd4;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             payload_last;
        logic [PortW-1:0] matched_port;
    } out_item_t;

    typedef struct packed {
        logic [2:0]                    port_count;
        logic [ListLen-1:0][PortW-1:0] ports;
    } port_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/tpf_cfg_regs.sv =====
`default_nettype none
module tpf_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [tpf_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [tpf_pkg::CfgDataW-1:0]  cfg_wdata,
    output tpf_pkg::port_cfg_t                 port_cfg
);

    tpf_pkg::port_cfg_t cfg_reg;
    tpf_pkg::port_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                tpf_pkg::CfgPortCount: cfg_next.port_count = cfg_wdata[2:0];
                tpf_pkg::CfgPortA:     cfg_next.ports[0] = cfg_wdata[15:0];
                tpf_pkg::CfgPortB:     cfg_next.ports[1] = cfg_wdata[15:0];
                tpf_pkg::CfgPortC:     cfg_next.ports[2] = cfg_wdata[15:0];
                tpf_pkg::CfgPortD:     cfg_next.ports[3] = cfg_wdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign port_cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/tpf_in_reg.sv =====
`default_nettype none
module tpf_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tpf_pkg::in_item_t s_item,
    output logic                   in_valid,
    input  wire logic              in_take,
    output tpf_pkg::in_item_t      in_item
);

    logic              valid_reg;
    logic              valid_next;
    tpf_pkg::in_item_t item_reg;
    logic              load;

    assign s_ready = !valid_reg || in_take;
    assign load = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (in_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item = item_reg;

endmodule
`default_nettype wire

// ===== rtl/tpf_parser.sv =====
`default_nettype none
module tpf_parser #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire tpf_pkg::in_item_t  in_item,
    output logic                    in_take,
    input  wire tpf_pkg::port_cfg_t port_cfg,
    input  wire logic               out_free,
    output logic                    res_valid,
    output tpf_pkg::out_item_t      res_item
);

    localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);
    localparam int Limit = (tpf_pkg::NumPorts < tpf_pkg::ListLen) ?
                           tpf_pkg::NumPorts : tpf_pkg::ListLen;

    logic [PosW-1:0]              pos_reg, pos_next;
    logic [5:0]                   hdr_reg, hdr_next;
    logic [6:0]                   hdr_end_reg, hdr_end_next;
    logic [tpf_pkg::PortW-1:0]    dport_reg, dport_next;
    logic                         hit_reg, hit_next;
    logic                         drop_reg, drop_next;
    logic [tpf_pkg::PortW-1:0]    hit_port_reg, hit_port_next;

    logic [PosW-1:0]              hdr_ext;
    logic [PosW-1:0]              off2, off3, off12;
    logic [tpf_pkg::PortW-1:0]    port_full;
    logic                         listed;
    logic                         active;
    logic                         produce;
    logic [7:0]                   b;
    logic [3:0]                   ihl;
    logic [3:0]                   doff;

    assign b = in_item.packet_byte;
    assign ihl = b[3:0];
    assign doff = b[7:4];
    assign hdr_ext = PosW'(hdr_reg);
    assign off2 = hdr_ext + PosW'(2);
    assign off3 = hdr_ext + PosW'(3);
    assign off12 = hdr_ext + PosW'(12);
    assign port_full = {dport_reg[15:8], b};
    assign active = (pos_reg != PosMax) && !drop_reg;

    always_comb begin
        listed = 1'b0;
        for (int i = 0; i < Limit; i++) begin
            if ((3'(i) < port_cfg.port_count) && (port_cfg.ports[i] == port_full)) begin
                listed = 1'b1;
            end
        end
    end

    assign produce = active && (pos_reg != '0) && (pos_reg != off2) && (pos_reg != off3)
                     && (pos_reg != off12) && (pos_reg > off12)
                     && (pos_reg >= PosW'(hdr_end_reg)) && hit_reg;

    assign in_take = in_valid && (!produce || out_free);
    assign res_valid = in_valid && produce && out_free;
    assign res_item.payload_byte = b;
    assign res_item.payload_last = in_item.end_of_packet;
    assign res_item.matched_port = hit_port_reg;

    always_comb begin
        pos_next = pos_reg;
        hdr_next = hdr_reg;
        hdr_end_next = hdr_end_reg;
        dport_next = dport_reg;
        hit_next = hit_reg;
        drop_next = drop_reg;
        hit_port_next = hit_port_reg;
        if (in_take) begin
            if (active) begin
                priority if (pos_reg == '0) begin
                    drop_next = (ihl <= tpf_pkg::MinHeaderWords);
                    hdr_next = {ihl, 2'b00};
                end else if (pos_reg == off2) begin
                    dport_next = {b, 8'h00};
                end else if (pos_reg == off3) begin
                    dport_next = port_full;
                    if (listed) begin
                        hit_next = 1'b1;
                        hit_port_next = port_full;
                    end
                end else if (pos_reg == off12) begin
                    drop_next = (doff <= tpf_pkg::MinHeaderWords);
                    hdr_end_next = 7'(hdr_reg) + {1'b0, doff, 2'b00};
                end else begin
                end
            end
            if (in_item.end_of_packet) begin
                pos_next = '0;
                hdr_next = '0;
                hdr_end_next = '0;
                dport_next = '0;
                hit_next = 1'b0;
                drop_next = 1'b0;
                hit_port_next = '0;
            end else if (pos_reg != PosMax) begin
                pos_next = pos_reg + PosW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            hdr_reg <= '0;
            hdr_end_reg <= '0;
            dport_reg <= '0;
            hit_reg <= 1'b0;
            drop_reg <= 1'b0;
            hit_port_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            hdr_end_reg <= hdr_end_next;
            dport_reg <= dport_next;
            hit_reg <= hit_next;
            drop_reg <= drop_next;
            hit_port_reg <= hit_port_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tpf_out_reg.sv =====
`default_nettype none
module tpf_out_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               res_valid,
    input  wire tpf_pkg::out_item_t res_item,
    output logic                    out_free,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tpf_pkg::out_item_t      m_item
);

    logic               valid_reg;
    logic               valid_next;
    tpf_pkg::out_item_t item_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            item_reg <= res_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item = item_reg;

endmodule
`default_nettype wire

// ===== rtl/tcp_port_payload_filter.sv =====
// IPv4/TCP destination port payload filter.
// s_valid/s_ready/s_item carry one datagram byte per item, starting at the IP
// header, with end_of_packet set on the final byte. m_valid/m_ready/m_item
// carry one TCP payload byte per item from packets whose destination port is
// in the listed ports, with payload_last and the matched port.
// cfg_we/cfg_index/cfg_wdata write port_count (0) and port_a..port_d (1..4);
// write only while no packet is in flight.
// An item passes an input register and a result register before its payload
// byte appears on m_valid. One item is taken every cycle unless a payload
// byte meets a full result register; the per-byte parse uses a position
// counter and a few header fields. A stalled m_ready holds the result
// register; further items that give no result still drain, and an item that
// gives one waits in the input register, which then drops s_ready.
// Reset clears the packet state, empties both registers and sets port_count
// and all listed ports to zero. Packets with IHL or data offset below 5 are
// dropped; bytes past MAX_PACKET_BYTES are discarded.
`default_nettype none
module tcp_port_payload_filter #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire tpf_pkg::in_item_t             s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tpf_pkg::out_item_t                 m_item,
    input  wire logic                          cfg_we,
    input  wire logic [tpf_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [tpf_pkg::CfgDataW-1:0]  cfg_wdata
);

    tpf_pkg::port_cfg_t port_cfg;
    tpf_pkg::in_item_t  in_item;
    tpf_pkg::out_item_t res_item;
    logic               in_valid;
    logic               in_take;
    logic               res_valid;
    logic               out_free;

    tpf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .port_cfg  (port_cfg)
    );

    tpf_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .in_valid (in_valid),
        .in_take  (in_take),
        .in_item  (in_item)
    );

    tpf_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_take   (in_take),
        .port_cfg  (port_cfg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    tpf_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_item  (res_item),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
`default_nettype wire
